// File: rtl/core/ble_command_byte_framer_core_macros.svh
// Assertion helpers shared by the bcbf_front and bcbf_queue modules.
`ifndef BLE_COMMAND_BYTE_FRAMER_CORE_MACROS_SVH
`define BLE_COMMAND_BYTE_FRAMER_CORE_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define BCBF_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BCBF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bcbf_pkg.sv
package bcbf_pkg;

    localparam int STORE_DEPTH = 4;
    localparam int COUNT_W     = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QCOUNT_W    = 2;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_AVOID = 2'd1;
    localparam logic [1:0] CMD_PARK  = 2'd2;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] RAW_AVOID = 8'h01;
    localparam logic [7:0] RAW_PARK  = 8'h02;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;

    typedef struct packed {
        logic [2:0] packet_length;
        logic [1:0] command;
    } t_packet;

endpackage

// File: rtl/core/bcbf_front.sv
`include "ble_command_byte_framer_core_macros.svh"

module bcbf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_rx_byte,
    output logic               o_ready,
    input  logic               i_full,
    output logic               o_push,
    output bcbf_pkg::t_packet  o_packet
);
    import bcbf_pkg::*;

    typedef logic [STORE_DEPTH-1:0][7:0] t_chars;

    function automatic logic [1:0] f_classify(input t_chars c, input logic [COUNT_W-1:0] n);
        logic park;
        logic stop;
        logic found;
        park  = (n == COUNT_W'(1) && c[0] == RAW_PARK) ||
                (n == COUNT_W'(2) && c[0] == CH_0 && c[1] == CH_2) ||
                (n == COUNT_W'(4) && c[0] == CH_0 && (c[1] == CH_X_LO || c[1] == CH_X_UP) &&
                 c[2] == CH_0 && c[3] == CH_2);
        stop  = 1'b0;
        found = 1'b0;
        for (int i = 0; i < STORE_DEPTH - 1; i++) begin
            if (!stop && COUNT_W'(i + 1) < n) begin
                if (c[i] == CH_NUL) begin
                    stop = 1'b1;
                end else if (c[i] == CH_0 && c[i+1] == CH_1) begin
                    found = 1'b1;
                end
            end
        end
        if (park) begin
            return CMD_PARK;
        end else if ((n == COUNT_W'(1) && c[0] == RAW_AVOID) || found) begin
            return CMD_AVOID;
        end
        return CMD_NONE;
    endfunction

    logic [7:0]         r_store [STORE_DEPTH-1];
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] w_new_count;
    logic [COUNT_W-1:0] w_len;
    t_chars             w_chars;
    logic               w_accept;
    logic               w_raw;
    logic               w_term;
    logic               w_done;

    assign o_ready     = !i_full;
    assign w_accept    = i_valid && o_ready;
    assign w_raw       = (i_rx_byte == RAW_AVOID) || (i_rx_byte == RAW_PARK);
    assign w_term      = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
    assign w_new_count = r_count + COUNT_W'(1);

    // Current packet as it reads with the incoming byte in its slot.
    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (COUNT_W'(i) == r_count) begin
                w_chars[i] = i_rx_byte;
            end else if (i < STORE_DEPTH - 1) begin
                w_chars[i] = r_store[i];
            end else begin
                w_chars[i] = CH_NUL;
            end
        end
    end

    assign w_done = (w_new_count == COUNT_W'(STORE_DEPTH)) ||
                    (w_new_count >= COUNT_W'(2) && w_chars[0] == CH_0 &&
                     (w_chars[1] == CH_1 || w_chars[1] == CH_2));
    assign w_len  = w_term ? r_count : w_new_count;

    always_comb begin
        n_count                = r_count;
        o_push                 = 1'b0;
        o_packet.command       = f_classify(w_chars, w_len);
        o_packet.packet_length = w_len;
        if (w_accept) begin
            if (w_raw) begin
                // Drop any partial packet and emit the control byte alone.
                o_push                 = 1'b1;
                o_packet.command       = (i_rx_byte == RAW_PARK) ? CMD_PARK : CMD_AVOID;
                o_packet.packet_length = COUNT_W'(1);
                n_count                = '0;
            end else if (w_term) begin
                o_push  = (r_count != '0);
                n_count = '0;
            end else if (w_done) begin
                o_push  = 1'b1;
                n_count = '0;
            end else begin
                n_count = w_new_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_raw && !w_term && !w_done) begin
            r_store[r_count[1:0]] <= i_rx_byte;
        end
    end

    `BCBF_ASSERT_ALWAYS(a_count_below_depth, i_clk, i_rst_n, r_count < COUNT_W'(STORE_DEPTH), "partial packet count reached store depth")
    `BCBF_ASSERT_IMPLIES(a_raw_emits, i_clk, i_rst_n, w_accept && w_raw, o_push, "raw control byte did not emit a packet")

endmodule

// File: rtl/core/bcbf_queue.sv
`include "ble_command_byte_framer_core_macros.svh"

module bcbf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bcbf_pkg::t_packet  i_packet,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output bcbf_pkg::t_packet  o_packet
);
    import bcbf_pkg::*;

    t_packet               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QCOUNT_W-1:0]   r_count;
    logic                  w_push;
    logic                  w_pop;

    assign o_full   = (r_count == QCOUNT_W'(QUEUE_DEPTH));
    assign o_empty  = (r_count == '0);
    assign w_push   = i_push && !o_full;
    assign w_pop    = i_pop && !o_empty;
    assign o_packet = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCOUNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCOUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_packet;
        end
    end

    `BCBF_ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, r_count <= QCOUNT_W'(QUEUE_DEPTH), "queue count past depth")
    `BCBF_ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "request pushed into full queue")

endmodule

// File: rtl/core/bcbf_back.sv
module bcbf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  bcbf_pkg::t_packet  i_packet,
    output logic               o_pop,
    output logic               o_valid,
    output logic [7:0]         o_data,
    input  logic               i_ready
);
    import bcbf_pkg::*;

    logic    r_valid;
    t_packet r_packet;

    // Load whenever the output slot is free or being taken this cycle.
    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = {3'b000, r_packet.packet_length, r_packet.command};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_packet <= i_packet;
        end
    end

endmodule

// File: rtl/core/ble_command_byte_framer_core.sv
// Path: a packet's result is written into the queue entry at the edge that accepts its final
//   byte, then moves to the output register that drives o_m_axis_tvalid; back-pressure can hold it.
// Throughput: one byte per cycle while the packet queue is not full; a two-entry packet queue
//   ahead of the output register keeps byte intake running while a result waits downstream.
// Reset (i_rst_n low, synchronous): clears the partial packet, the queue and the output.
module ble_command_byte_framer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata    // [1:0] command, [4:2] packet_length, [7:5] zero
);
    import bcbf_pkg::*;

    t_packet w_front_packet;
    t_packet w_queue_packet;
    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_empty;

    bcbf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_rx_byte (i_s_axis_tdata),
        .o_ready   (o_s_axis_tready),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_packet  (w_front_packet)
    );

    bcbf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_packet (w_front_packet),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_empty  (w_empty),
        .o_packet (w_queue_packet)
    );

    bcbf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_packet (w_queue_packet),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .o_data   (o_m_axis_tdata),
        .i_ready  (i_m_axis_tready)
    );

endmodule
